[design/nps_pkg.sv]
// nps_pkg: shared widths, codes and payload types for the nearest point search block
// no dependencies; compiled before the interfaces and the top level
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    // squared distance of one axis, and the sum of both axes
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_absdiff;
    typedef logic [SQ_W-1:0]           t_sq;
    typedef logic [DIST_W-1:0]         t_dist;

    // operation codes of a request word
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // one stored table entry
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord floor_h;
        t_coord ceiling_h;
    } t_entry;

    localparam t_cnt SCAN_LIMIT = t_cnt'(MAX_POINTS);

endpackage

[design/nps_intf.sv]
// nps_intf: valid/ready channel interfaces for config, request and response words
// depends on nps_pkg
`timescale 1ns / 1ps

// configuration write channel, one register, no address
interface nps_cfg_if;
    import nps_pkg::*;
    logic valid;
    logic ready;
    t_cnt point_count;

    modport source (output valid, output point_count, input ready);
    modport sink   (input valid, input point_count, output ready);
endinterface

// request channel: table write or nearest point query
interface nps_req_if;
    import nps_pkg::*;
    logic   valid;
    logic   ready;
    logic   op;
    t_idx   entry_index;
    t_coord entry_x;
    t_coord entry_y;
    t_coord entry_floor;
    t_coord entry_ceiling;
    t_coord query_x;
    t_coord query_y;
    t_coord height_max;
    t_coord height_min;
    logic   filter_enable;

    modport source (
        output valid, output op, output entry_index, output entry_x, output entry_y,
        output entry_floor, output entry_ceiling, output query_x, output query_y,
        output height_max, output height_min, output filter_enable,
        input  ready
    );
    modport sink (
        input  valid, input op, input entry_index, input entry_x, input entry_y,
        input  entry_floor, input entry_ceiling, input query_x, input query_y,
        input  height_max, input height_min, input filter_enable,
        output ready
    );
endinterface

// response channel: one word per query
interface nps_rsp_if;
    import nps_pkg::*;
    logic valid;
    logic ready;
    logic found;
    t_idx nearest_index;

    modport source (output valid, output found, output nearest_index, input ready);
    modport sink   (input valid, input found, input nearest_index, output ready);
endinterface

[design/nearest_point_search.sv]
// nearest_point_search: point table in a 1024-entry memory plus a scanning distance unit
// query: scans point_count entries (saturated to 1024), drains the distance pipeline, then responds
// (a count of 0 scans and drains nothing); table write: no response; the block takes one request at a time
// throughput set by the single memory read port, one table entry per cycle
// reset (synchronous, active low) clears control and point_count; table contents are unknown
// depends on nps_pkg and nps_intf
`timescale 1ns / 1ps

module nearest_point_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nps_cfg_if.sink     i_cfg,
    nps_req_if.sink     i_req,
    nps_rsp_if.source   o_rsp
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    // control
    t_cnt   r_point_count;
    t_cnt   r_scan_n;
    t_cnt   r_addr;
    logic   r_v1, r_v2, r_v3;
    logic   r_found;
    logic   r_out_valid;
    logic   r_out_found;
    t_idx   r_out_idx;

    // query operands
    t_coord r_qx, r_qy, r_hmax, r_hmin;
    logic   r_filt;

    // table memory and scan pipeline
    t_entry r_mem [MAX_POINTS];
    t_entry r_rd;
    t_idx   r_idx1, r_idx2, r_idx3;
    t_absdiff r_dx, r_dy;
    logic   r_q2, r_q3;
    t_sq    r_sqx, r_sqy;
    t_dist  r_best;
    t_idx   r_best_idx;

    logic   w_req_acc;
    logic   w_issue;
    logic   w_drained;
    logic   w_take;
    t_dist  w_dist;
    t_cnt   w_scan_n;
    logic signed [COORD_W:0] w_diff_x, w_diff_y;
    t_absdiff w_abs_x, w_abs_y;
    logic   w_qual;

    // handshake and sequencing terms
    always_comb begin
        w_req_acc = i_req.valid && i_req.ready;
        w_issue   = (r_state == S_SCAN) && (r_addr < r_scan_n);
        w_drained = !r_v1 && !r_v2 && !r_v3;
        w_scan_n  = (r_point_count > SCAN_LIMIT) ? SCAN_LIMIT : r_point_count;
    end

    assign i_cfg.ready         = 1'b1;
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found         = r_out_found;
    assign o_rsp.nearest_index = r_out_idx;

    // table memory: one write port from requests, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_req_acc && (t_op'(i_req.op) == OP_WRITE)) begin
            r_mem[i_req.entry_index] <= '{x: i_req.entry_x, y: i_req.entry_y,
                                          floor_h: i_req.entry_floor,
                                          ceiling_h: i_req.entry_ceiling};
        end
        r_rd <= r_mem[r_addr[IDX_W-1:0]];
    end

    // per-axis distance and height filter on the word read back
    always_comb begin
        w_diff_x = {r_rd.x[COORD_W-1], r_rd.x} - {r_qx[COORD_W-1], r_qx};
        w_diff_y = {r_rd.y[COORD_W-1], r_rd.y} - {r_qy[COORD_W-1], r_qy};
        w_abs_x  = w_diff_x[COORD_W] ? t_absdiff'(-w_diff_x) : t_absdiff'(w_diff_x);
        w_abs_y  = w_diff_y[COORD_W] ? t_absdiff'(-w_diff_y) : t_absdiff'(w_diff_y);
        w_qual   = !r_filt || ((r_rd.floor_h >= r_hmin) && (r_rd.ceiling_h <= r_hmax));
    end

    // sum of squares and strict compare against the running best
    always_comb begin
        w_dist = t_dist'(r_sqx) + t_dist'(r_sqy);
        w_take = r_v3 && r_q3 && (!r_found || (w_dist < r_best));
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_req_acc && (t_op'(i_req.op) == OP_QUERY)) begin
            r_qx   <= i_req.query_x;
            r_qy   <= i_req.query_y;
            r_hmax <= i_req.height_max;
            r_hmin <= i_req.height_min;
            r_filt <= i_req.filter_enable;
        end
        r_idx1 <= r_addr[IDX_W-1:0];
        r_idx2 <= r_idx1;
        r_dx   <= w_abs_x;
        r_dy   <= w_abs_y;
        r_q2   <= w_qual;
        r_idx3 <= r_idx2;
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_q3   <= r_q2;
        if (w_take) begin
            r_best     <= w_dist;
            r_best_idx <= r_idx3;
        end
    end

    // sequencer, scan counter and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= '0;
            r_scan_n      <= '0;
            r_addr        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_found   <= 1'b0;
            r_out_idx     <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_point_count <= i_cfg.point_count;
            end
            // a word taken while the next one is formed is replaced below
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_take) begin
                r_found <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_req_acc && (t_op'(i_req.op) == OP_QUERY)) begin
                        r_scan_n <= w_scan_n;
                        r_addr   <= '0;
                        r_found  <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!w_issue && w_drained) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_idx   <= r_found ? r_best_idx : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // scan address never runs past the entry count
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= r_scan_n)
        else $error("scan address beyond entry count");

    // every entry was issued before the result is formed
    a_scan_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_addr == r_scan_n))
        else $error("result formed before scan completed");

    // distance pipeline is empty whenever a new request can be taken
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline busy while idle");

    // a new response word only follows the end of a scan
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside result state");
`endif

endmodule
